// ===== rtl/pm_pkg.sv =====
// Shared types, constants and a helper function of the polynomial multiplier.
package pm_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int COEF_W  = 32;
    localparam int POWER_W = 6;
    localparam int CNT_W   = 6;
    localparam int ADDR_W  = 5;
    localparam int FRAC_BITS = 16;

    // Depth of the command queue between the front and back parts.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;

    localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

    // One input transaction.
    typedef struct packed {
        logic signed [COEF_W-1:0] coef_value;
        logic                     operand_sel;
        logic                     operand_last;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic signed [COEF_W-1:0] prod_value;
        logic [POWER_W-1:0]       power_index;
        logic                     prod_last;
    } t_out_item;

    // Kind of work the back part carries out for one command.
    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_RUN
    } t_cmd_op;

    // Classified command passed from the front to the back part.
    typedef struct packed {
        t_cmd_op             op;
        logic                wr;
        logic [ADDR_W-1:0]   addr;
        logic [COEF_W-1:0]   coef;
        logic [CNT_W-1:0]    na;
        logic [CNT_W-1:0]    nb;
        logic                a_zero;
        logic                b_zero;
    } t_cmd;

    // Command queue write side.
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_cmd_wr;

    // Command queue read side status.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_rd;

    // Back part sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SETUP,
        BK_ISSUE,
        BK_DRAIN,
        BK_ROUND,
        BK_CLAMP,
        BK_EMIT
    } t_back_state;

    // Signed 64-bit add that sticks at the limits on overflow.
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            s = a[63] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

endpackage

// ===== rtl/pm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/pm_front.sv =====
// Front part: accepts coefficient transactions, tracks operand counts and classifies them.
module pm_front #(
    parameter int MAX_TERMS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  pm_pkg::t_in_item i_in_item,
    input  logic             i_q_full,
    output pm_pkg::t_cmd_wr  o_q_wr
);
    import pm_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

    logic [CNT_W-1:0] r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0] r_cnt_b, n_cnt_b;
    logic             r_a_closed, n_a_closed;
    logic             accept;
    logic [CNT_W-1:0] slot_a;
    logic [CNT_W-1:0] cnt_b_upd;
    t_cmd             cmd;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;

    // An A transaction after A was closed starts a fresh operand A.
    assign slot_a    = r_a_closed ? '0 : r_cnt_a;
    assign cnt_b_upd = (r_cnt_b < MAX_CNT) ? r_cnt_b + 1'b1 : r_cnt_b;

    // Classify the transaction and compute the next operand counts.
    always_comb begin
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_a_closed = r_a_closed;
        cmd        = '0;
        cmd.coef   = i_in_item.coef_value;
        cmd.na     = (r_cnt_a == '0) ? CNT_W'(1) : r_cnt_a;
        cmd.nb     = (cnt_b_upd == '0) ? CNT_W'(1) : cnt_b_upd;
        cmd.a_zero = (r_cnt_a == '0);
        cmd.b_zero = (cnt_b_upd == '0);
        if (!i_in_item.operand_sel) begin
            cmd.op   = CMD_LOAD_A;
            cmd.wr   = (slot_a < MAX_CNT);
            cmd.addr = ADDR_W'(slot_a);
            if (accept) begin
                n_cnt_a    = (slot_a < MAX_CNT) ? slot_a + 1'b1 : slot_a;
                n_a_closed = i_in_item.operand_last;
            end
        end else begin
            cmd.op   = i_in_item.operand_last ? CMD_RUN : CMD_LOAD_B;
            cmd.wr   = (r_cnt_b < MAX_CNT);
            cmd.addr = ADDR_W'(r_cnt_b);
            if (accept) begin
                if (i_in_item.operand_last) begin
                    n_cnt_a    = '0;
                    n_cnt_b    = '0;
                    n_a_closed = 1'b0;
                end else begin
                    n_cnt_b = cnt_b_upd;
                end
            end
        end
    end

    // Operand bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_a_closed <= 1'b0;
        end else begin
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_a_closed <= n_a_closed;
        end
    end

    assign o_q_wr.push = accept;
    assign o_q_wr.cmd  = cmd;

endmodule

// ===== rtl/pm_cmd_fifo.sv =====
// Short command queue between the front and back parts.
module pm_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pm_pkg::t_cmd_wr i_wr,
    output logic            o_full,
    input  logic            i_pop,
    output pm_pkg::t_cmd_rd o_rd
);
    import pm_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_cnt;
    logic                 do_wr;
    logic                 do_rd;

    assign o_full = (r_cnt == CMD_CNT_W'(CMD_DEPTH));
    assign do_wr  = i_wr.push && !o_full;
    assign do_rd  = i_pop && (r_cnt != '0);

    // Storage of queued commands.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr.cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.cmd   = r_mem[r_rd_ptr];

endmodule

// ===== rtl/pm_back.sv =====
// Back part: coefficient stores, multiply-accumulate sequencer and result register.
module pm_back #(
    parameter int MAX_TERMS = 32,
    parameter int COEF_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pm_pkg::t_cmd_rd   i_q_rd,
    output logic              o_q_pop,
    output logic              empty,
    input  logic              pop,
    output pm_pkg::t_out_item o_out_item
);
    import pm_pkg::*;

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COEF_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam logic signed [63:0] HALF   = 64'sd1 <<< (FRAC_BITS - 1);

    t_back_state r_state, n_state;

    logic [CNT_W-1:0]   r_na, r_nb;
    logic               r_a_zero, r_b_zero;
    logic [POWER_W-1:0] r_k, r_k_last;
    logic [CNT_W-1:0]   r_i, r_i_hi;
    logic               r_rd_vld, r_prod_vld;
    logic signed [63:0] r_prod, r_acc;
    logic signed [COEF_W-1:0] r_res;
    logic               r_out_vld;
    t_out_item          r_out;

    logic               cmd_take;
    logic               run_start;
    logic               issue;
    logic               out_load;
    logic               we_a, we_b;
    logic [COEF_BITS-1:0] q_a, q_b;
    logic [CNT_W-1:0]   b_idx;
    logic [CNT_W-1:0]   i_lo_c, i_hi_c;
    logic signed [COEF_W-1:0] a_op, b_op;
    logic signed [63:0] prod_c;
    logic signed [63:0] shifted;
    t_cmd               cmd;

    assign cmd = i_q_rd.cmd;

    // Write enables for the two coefficient stores.
    always_comb begin
        we_a = 1'b0;
        we_b = 1'b0;
        unique case (cmd.op)
            CMD_LOAD_A:         we_a = cmd_take && cmd.wr;
            CMD_LOAD_B, CMD_RUN: we_b = cmd_take && cmd.wr;
            default: begin
                we_a = 1'b0;
                we_b = 1'b0;
            end
        endcase
    end

    assign b_idx = CNT_W'(r_k) - r_i;

    pm_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TERMS)) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (we_a),
        .i_wr_addr (cmd.addr[IDX_W-1:0]),
        .i_wr_data (cmd.coef[COEF_BITS-1:0]),
        .i_rd_en   (issue),
        .i_rd_addr (r_i[IDX_W-1:0]),
        .o_rd_data (q_a)
    );

    pm_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TERMS)) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (we_b),
        .i_wr_addr (cmd.addr[IDX_W-1:0]),
        .i_wr_data (cmd.coef[COEF_BITS-1:0]),
        .i_rd_en   (issue),
        .i_rd_addr (b_idx[IDX_W-1:0]),
        .o_rd_data (q_b)
    );

    // Term range for the current power: max(0, k-nb+1) up to min(k, na-1).
    assign i_lo_c = (CNT_W'(r_k) >= r_nb) ? CNT_W'(r_k) - r_nb + 1'b1 : '0;
    assign i_hi_c = (CNT_W'(r_k) < r_na) ? CNT_W'(r_k) : r_na - 1'b1;

    // An empty operand reads as the single zero coefficient.
    assign a_op   = r_a_zero ? '0 : COEF_W'(signed'(q_a));
    assign b_op   = r_b_zero ? '0 : COEF_W'(signed'(q_b));
    assign prod_c = a_op * b_op;
    assign shifted = r_acc >>> FRAC_BITS;

    // Sequencer next state and control outputs.
    always_comb begin
        n_state   = r_state;
        cmd_take  = 1'b0;
        run_start = 1'b0;
        issue     = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_rd.valid) begin
                    cmd_take = 1'b1;
                    if (cmd.op == CMD_RUN) begin
                        run_start = 1'b1;
                        n_state   = BK_SETUP;
                    end
                end
            end
            BK_SETUP: begin
                n_state = BK_ISSUE;
            end
            BK_ISSUE: begin
                issue = 1'b1;
                if (r_i == r_i_hi) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (!r_rd_vld && !r_prod_vld) begin
                    n_state = BK_ROUND;
                end
            end
            BK_ROUND: begin
                n_state = BK_CLAMP;
            end
            BK_CLAMP: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (!r_out_vld || pop) begin
                    out_load = 1'b1;
                    n_state  = (r_k == r_k_last) ? BK_IDLE : BK_SETUP;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pipeline valid flags and the result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld   <= issue;
            r_prod_vld <= r_rd_vld;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Operand sizes, loop indexes and the multiply-accumulate datapath.
    always_ff @(posedge i_clk) begin
        if (run_start) begin
            r_na     <= cmd.na;
            r_nb     <= cmd.nb;
            r_a_zero <= cmd.a_zero;
            r_b_zero <= cmd.b_zero;
            r_k      <= '0;
            r_k_last <= POWER_W'(cmd.na + cmd.nb - 2'd2);
        end else if (out_load) begin
            r_k <= r_k + 1'b1;
        end

        if (r_state == BK_SETUP) begin
            r_i    <= i_lo_c;
            r_i_hi <= i_hi_c;
        end else if (issue) begin
            r_i <= r_i + 1'b1;
        end

        r_prod <= prod_c;

        // Terms are summed in ascending order of the A index.
        if (r_state == BK_SETUP) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= sat_add64(r_acc, r_prod);
        end else if (r_state == BK_ROUND) begin
            r_acc <= sat_add64(r_acc, HALF);
        end

        // Drop the fraction bits and clamp to the coefficient range.
        if (r_state == BK_CLAMP) begin
            if (shifted > SAT_HI) begin
                r_res <= COEF_W'(SAT_HI);
            end else if (shifted < SAT_LO) begin
                r_res <= COEF_W'(SAT_LO);
            end else begin
                r_res <= COEF_W'(shifted);
            end
        end

        if (out_load) begin
            r_out.prod_value  <= r_res;
            r_out.power_index <= r_k;
            r_out.prod_last   <= (r_k == r_k_last);
        end
    end

    assign o_q_pop    = cmd_take;
    assign empty      = !r_out_vld;
    assign o_out_item = r_out;

endmodule

// ===== rtl/polynomial_multiply.sv =====
// Top level of the fixed-point polynomial multiplier.
//
// Channel   | Handshake        | Payload      | Transaction
// ----------+------------------+--------------+-----------------------------------------
// input     | push / full      | i_in_item    | one coefficient of operand A or B
// result    | empty / pop      | o_out_item   | one product coefficient with its power
//
// In the back part a coefficient load is written to its store in the same cycle as it leaves the command queue.
// A product is computed with one multiply-accumulate per cycle
// through the single multiplier and the registered store reads, plus setup, drain, rounding,
// clamping and hand-off for each power.
// Reset is synchronous and active low; the coefficient stores are not cleared.
// Input transactions keep entering the four-entry command queue during a product until it fills,
// and a result waiting in the output register stalls the back part, then the input once the queue is full.
module polynomial_multiply #(
    parameter int MAX_TERMS = 32,
    parameter int COEF_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pm_pkg::t_in_item   i_in_item,
    output logic               empty,
    input  logic               pop,
    output pm_pkg::t_out_item  o_out_item
);
    import pm_pkg::*;

    t_cmd_wr q_wr;
    t_cmd_rd q_rd;
    logic    q_full;
    logic    q_pop;

    pm_front #(.MAX_TERMS(MAX_TERMS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .i_q_full  (q_full),
        .o_q_wr    (q_wr)
    );

    pm_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    pm_back #(.MAX_TERMS(MAX_TERMS), .COEF_BITS(COEF_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_rd     (q_rd),
        .o_q_pop    (q_pop),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    // Powers of one product come out in ascending order without gaps.
    a_power_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_out_item.prod_last) |=>
            (empty || (o_out_item.power_index == $past(o_out_item.power_index) + 1'b1)))
        else $error("product coefficient power did not advance by one");

    // A new product starts at power zero.
    a_power_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_out_item.prod_last) |=>
            (empty || (o_out_item.power_index == '0)))
        else $error("product did not restart at power zero");

    // The highest possible power is always the final coefficient.
    a_top_power_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out_item.power_index == POWER_W'(2 * MAX_TERMS - 2))) |->
            o_out_item.prod_last)
        else $error("highest power not marked last");

endmodule

// ===== tb/polynomial_multiply_tb.sv =====
// Self-checking testbench for the fixed-point polynomial multiplier.
`timescale 1ns / 100ps

module polynomial_multiply_tb;
    import pm_pkg::*;

    // Operand select codes and frequently used coefficient values.
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;
    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] C_ONE = 32'h0001_0000;

    localparam int TERMS = 32;
    localparam int FRAC = 16;
    localparam int RANDOM_ITEMS = 350;
    localparam logic signed [63:0] WORD_TOP = 64'sd2147483647;
    localparam logic signed [63:0] WORD_BOT = -64'sd2147483648;

    // One row of the directed plan; want is only used when check is set.
    typedef struct packed {
        logic        sel;
        logic        last;
        logic [31:0] coef;
        logic        check;
        logic [31:0] want;
    } t_row;

    localparam int PLAN_LEN = 23;
    localparam t_row PLAN [PLAN_LEN] = '{
        '{SEL_B, 1'b1, C_MAX,         1'b1, 32'h0000_0000}, // A never loaded
        '{SEL_A, 1'b1, C_ONE,         1'b0, 32'h0},
        '{SEL_B, 1'b1, C_ONE,         1'b1, C_ONE},
        '{SEL_A, 1'b1, C_MAX,         1'b0, 32'h0},
        '{SEL_B, 1'b1, C_MAX,         1'b1, C_MAX},
        '{SEL_A, 1'b1, C_MIN,         1'b0, 32'h0},
        '{SEL_B, 1'b1, C_MAX,         1'b1, C_MIN},
        '{SEL_A, 1'b1, C_MIN,         1'b0, 32'h0},
        '{SEL_B, 1'b1, C_MIN,         1'b1, C_MAX},
        '{SEL_A, 1'b1, 32'h0000_0001, 1'b0, 32'h0},         // rounding tie goes up
        '{SEL_B, 1'b1, 32'h0000_8000, 1'b1, 32'h0000_0001},
        '{SEL_A, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{SEL_B, 1'b1, 32'h0000_8000, 1'b1, 32'h0000_0000},
        '{SEL_A, 1'b1, 32'h0002_0000, 1'b0, 32'h0},         // closed A is replaced
        '{SEL_A, 1'b1, 32'h0003_0000, 1'b0, 32'h0},
        '{SEL_B, 1'b1, C_ONE,         1'b1, 32'h0003_0000},
        '{SEL_A, 1'b0, C_ONE,         1'b0, 32'h0},
        '{SEL_A, 1'b1, 32'h0002_0000, 1'b0, 32'h0},
        '{SEL_B, 1'b0, 32'h0003_0000, 1'b0, 32'h0},
        '{SEL_B, 1'b0, 32'hFFFC_0000, 1'b0, 32'h0},
        '{SEL_B, 1'b1, 32'h0005_0000, 1'b0, 32'h0},
        '{SEL_A, 1'b0, 32'h1234_5678, 1'b0, 32'h0},         // B arrives while A is open
        '{SEL_B, 1'b1, 32'hEDCB_A987, 1'b0, 32'h0}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop;
    t_out_item o_out_item;

    // Shadow copy of the operand stores and the expected product coefficients.
    logic signed [31:0] coef_a [TERMS];
    logic signed [31:0] coef_b [TERMS];
    int                 terms_a;
    int                 terms_b;
    bit                 a_done;
    t_out_item          staged [$];
    t_out_item          products_due [$];

    int  errors;
    int  sent;
    int  products;
    int  coefs_checked;
    bit  steady;

    polynomial_multiply dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Signed 64-bit add that pins at the limits.
    function automatic logic signed [63:0] add_clip(input logic signed [63:0] x,
                                                    input logic signed [63:0] y);
        logic signed [64:0] s;
        s = 65'(x) + 65'(y);
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    // Update the shadow stores and stage the product when B closes.
    task automatic track_item(input t_in_item it);
        int na;
        int nb;
        int k;
        int i;
        logic signed [63:0] acc;
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        t_out_item r;
        if (it.operand_sel == SEL_A) begin
            if (a_done) begin
                terms_a = 0;
                a_done = 1'b0;
            end
            if (terms_a < TERMS) begin
                coef_a[terms_a] = it.coef_value;
                terms_a++;
            end
            if (it.operand_last) begin
                a_done = 1'b1;
            end
        end else begin
            if (terms_b < TERMS) begin
                coef_b[terms_b] = it.coef_value;
                terms_b++;
            end
            if (it.operand_last) begin
                na = (terms_a != 0) ? terms_a : 1;
                nb = (terms_b != 0) ? terms_b : 1;
                for (k = 0; k < na + nb - 1; k++) begin
                    acc = '0;
                    for (i = 0; i < na; i++) begin
                        if (i <= k && k - i < nb) begin
                            // An empty operand reads as the zero polynomial.
                            pa = (i < terms_a) ? 64'(coef_a[i]) : 64'sd0;
                            pb = (k - i < terms_b) ? 64'(coef_b[k - i]) : 64'sd0;
                            acc = add_clip(acc, pa * pb);
                        end
                    end
                    acc = add_clip(acc, 64'sd1 <<< (FRAC - 1));
                    acc = acc >>> FRAC;
                    if (acc > WORD_TOP) begin
                        r.prod_value = WORD_TOP[31:0];
                    end else if (acc < WORD_BOT) begin
                        r.prod_value = WORD_BOT[31:0];
                    end else begin
                        r.prod_value = acc[31:0];
                    end
                    r.power_index = 6'(k);
                    r.prod_last = (k == na + nb - 2);
                    staged.push_back(r);
                end
                terms_a = 0;
                terms_b = 0;
                a_done = 1'b0;
                products++;
            end
        end
    endtask

    // Offer one transaction, wait until it is taken, then record what it should produce.
    task automatic send_item(input t_in_item it, input logic check, input logic [31:0] want);
        t_out_item r;
        while (!steady && $urandom_range(99) < 33) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        track_item(it);
        if (check) begin
            staged.delete();
            r.prod_value = want;
            r.power_index = '0;
            r.prod_last = 1'b1;
            products_due.push_back(r);
        end else begin
            while (staged.size() > 0) begin
                products_due.push_back(staged.pop_front());
            end
        end
        sent++;
        @(negedge i_clk);
    endtask

    // Random coefficient: extremes, zero, small values and full-range words.
    function automatic logic signed [31:0] pick_coef();
        logic signed [19:0] s;
        case ($urandom_range(9))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3, 4, 5: begin
                s = 20'($urandom);
                return s;
            end
            default: return $urandom;
        endcase
    endfunction

    // Send len coefficients of one operand, closing it on the final one if asked.
    task automatic send_operand(input logic sel, input int len, input bit close,
                                input bit extremes);
        t_in_item it;
        int n;
        for (n = 0; n < len; n++) begin
            it.operand_sel = sel;
            it.operand_last = close && (n == len - 1);
            if (extremes) begin
                it.coef_value = $urandom_range(1) ? C_MAX : C_MIN;
            end else begin
                it.coef_value = pick_coef();
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // Mostly short operands, now and then one near or past the store depth.
    function automatic int pick_len();
        if ($urandom_range(11) == 0) begin
            return $urandom_range(34, 25);
        end
        return $urandom_range(6, 1);
    endfunction

    // Stimulus.
    initial begin
        t_in_item it;
        int r;
        int base;
        int la;
        int lb;
        int shape;
        bit ext;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_in_item = '0;
        errors = 0;
        sent = 0;
        products = 0;
        coefs_checked = 0;
        steady = 1'b0;
        terms_a = 0;
        terms_b = 0;
        a_done = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed plan.
        for (r = 0; r < PLAN_LEN; r++) begin
            it.coef_value = PLAN[r].coef;
            it.operand_sel = PLAN[r].sel;
            it.operand_last = PLAN[r].last;
            send_item(it, PLAN[r].check, PLAN[r].want);
        end

        // Both operands past capacity, with extreme terms so the sums saturate.
        send_operand(SEL_A, 34, 1'b1, 1'b1);
        send_operand(SEL_B, 34, 1'b1, 1'b1);

        // Random products, with a share of malformed operand sequences.
        base = sent;
        while (sent < base + RANDOM_ITEMS) begin
            steady = (sent - base >= 180) && (sent - base < 260);
            la = pick_len();
            lb = pick_len();
            ext = (la > 6 || lb > 6) ? $urandom_range(1) : ($urandom_range(9) == 0);
            shape = $urandom_range(19);
            if (shape == 1) begin
                // A is never closed before B starts.
                send_operand(SEL_A, la, 1'b0, ext);
            end else if (shape == 2) begin
                // A closed A is replaced by a second one.
                send_operand(SEL_A, pick_len(), 1'b1, ext);
                send_operand(SEL_A, la, 1'b1, ext);
            end else if (shape != 0) begin
                send_operand(SEL_A, la, 1'b1, ext);
            end
            send_operand(SEL_B, lb, 1'b1, ext);
        end
        steady = 1'b0;
        push <= 1'b0;

        // Drain, then give any stray result time to show up.
        wait (products_due.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Loaded %0d coefficients (%0d directed), %0d products, %0d coefficients checked.",
                 sent, base, products, coefs_checked);
        $display("Covered empty and open A, replaced A, operands past capacity and saturation.");
        if (errors == 0) begin
            $display("polynomial_multiply_tb: done, clean");
        end else begin
            $display("polynomial_multiply_tb: done, errors");
        end
        $finish;
    end

    // Result side stalls.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= steady || ($urandom_range(99) >= 33);
        end
    end

    // Compare each accepted result with the oldest expected coefficient.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (products_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h power %0d last %b",
                         $time, o_out_item.prod_value, o_out_item.power_index,
                         o_out_item.prod_last);
                errors++;
            end else begin
                want = products_due.pop_front();
                coefs_checked++;
                if (o_out_item.prod_value !== want.prod_value) begin
                    $display("%0t: prod_value at power %0d: expected %h, got %h", $time,
                             want.power_index, want.prod_value, o_out_item.prod_value);
                    errors++;
                end
                if (o_out_item.power_index !== want.power_index) begin
                    $display("%0t: power_index: expected %0d, got %0d", $time,
                             want.power_index, o_out_item.power_index);
                    errors++;
                end
                if (o_out_item.prod_last !== want.prod_last) begin
                    $display("%0t: prod_last at power %0d: expected %b, got %b", $time,
                             want.power_index, want.prod_last, o_out_item.prod_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, products_due.size());
        $display("polynomial_multiply_tb: done, errors");
        $finish;
    end

endmodule
